// ===== rtl/bridge_deal_text_parser_assert.svh =====
// assertion macros for the deal text parser, used by bdtp_back
// no dependencies; included inside module bodies
`ifndef BRIDGE_DEAL_TEXT_PARSER_ASSERT_SVH
`define BRIDGE_DEAL_TEXT_PARSER_ASSERT_SVH

// same-cycle implication
`define BDTP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdtp assertion failed (same cycle)");

// next-cycle implication
`define BDTP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdtp assertion failed (next cycle)");

`endif

// ===== rtl/bdtp_pkg.sv =====
// types and constants of the bridge deal text parser
// no dependencies; imported by every module of the block except bdtp_ram
package bdtp_pkg;

   localparam int NUM_CARDS  = 52;
   localparam int HAND_SIZE  = 13;
   localparam int CARD_IDX_W = $clog2(NUM_CARDS);

   localparam logic [1:0] SUIT_CLUBS  = 2'd0;
   localparam logic [1:0] SUIT_SPADES = 2'd3;

   localparam logic [7:0] MIN_LENGTH_RESET = 8'd76;

   typedef enum logic [2:0] {
      VERDICT_OK        = 3'd0,
      VERDICT_TOO_SHORT = 3'd1,
      VERDICT_INVALID   = 3'd2,
      VERDICT_OVERFLOW  = 3'd3,
      VERDICT_BAD_CARDS = 3'd4
   } verdict_type;

   typedef enum logic {
      KIND_CARD    = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [5:0]  slot_index;
      logic [1:0]  suit_id;
      logic [3:0]  rank_id;
      verdict_type verdict;
      logic [5:0]  bad_card_count;
      logic        last_result;
   } rsp_type;

   // one queued operation for the tally stage
   typedef struct packed {
      logic                  has_card;
      logic [CARD_IDX_W-1:0] card_index;
      logic [5:0]            slot;
      logic [1:0]            suit;
      logic [3:0]            rank;
      logic                  has_verdict;
      logic                  tally;
      verdict_type           verdict;
   } op_type;

endpackage

// ===== rtl/bridge_deal_text_parser.sv =====
// Bridge deal text parser, top level. Takes one character per cycle on the
// request channel and answers each card with a card write and the final
// character with a verdict. The tally stage retires one operation per cycle,
// except that a character that both places a card and ends the string yields
// two responses, a card write and then a verdict, and holds the tally stage
// for both; the QUEUE_DEPTH-entry queue between the classifier and the tally
// stage absorbs these, so only a long run of such characters or a stalled
// response channel slows the request side.
// Per-card seen counters sit in a 52 x 2 ram with a valid flag per card, so
// the verdict clears the tally by clearing the valid flags and reset needs
// no clearing pass. min_length is written through csr_wr_en/csr_wr_data;
// the user must write it only while idle, which the block does not enforce.
// depends on bdtp_pkg, bdtp_front, bdtp_fifo, bdtp_back
module bridge_deal_text_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdtp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdtp_pkg::rsp_type rsp_data
);

   import bdtp_pkg::*;

   logic [7:0] min_length_ff, min_length_in;
   logic       push_valid;
   logic       push_ready;
   op_type     push_data;
   logic       pop_valid;
   logic       pop_ready;
   op_type     pop_data;

   assign min_length_in = csr_wr_en ? csr_wr_data : min_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
      end else begin
         min_length_ff <= min_length_in;
      end
   end

   bdtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .min_length(min_length_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   bdtp_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   bdtp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data (pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/bdtp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module bdtp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 52
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bdtp_front.sv =====
// character classifier and parse state of the deal text parser
// depends on bdtp_pkg; feeds operations into bdtp_fifo
module bdtp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        min_length,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdtp_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output bdtp_pkg::op_type  push_data
);

   import bdtp_pkg::*;

   localparam logic [7:0] CHAR_TWO     = 8'h32;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_TEN     = 8'h54;
   localparam logic [7:0] CHAR_JACK    = 8'h4A;
   localparam logic [7:0] CHAR_QUEEN   = 8'h51;
   localparam logic [7:0] CHAR_KING    = 8'h4B;
   localparam logic [7:0] CHAR_ACE     = 8'h41;
   localparam logic [7:0] CHAR_NORTH   = 8'h6E;
   localparam logic [7:0] CHAR_EAST    = 8'h65;
   localparam logic [7:0] CHAR_SOUTH   = 8'h73;
   localparam logic [7:0] CHAR_WEST    = 8'h77;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [1:0] SEAT_NORTH = 2'd0;
   localparam logic [1:0] SEAT_EAST  = 2'd1;
   localparam logic [1:0] SEAT_SOUTH = 2'd2;
   localparam logic [1:0] SEAT_WEST  = 2'd3;

   localparam logic [3:0] RANK_NONE = 4'd13;

   function automatic logic [3:0] rank_of(input logic [7:0] c);
      logic [3:0] r;
      if (c >= CHAR_TWO && c <= CHAR_NINE) begin
         r = 4'(c - CHAR_TWO);
      end else begin
         case (c)
            CHAR_TEN:   r = 4'd8;
            CHAR_JACK:  r = 4'd9;
            CHAR_QUEEN: r = 4'd10;
            CHAR_KING:  r = 4'd11;
            CHAR_ACE:   r = 4'd12;
            default:    r = RANK_NONE;
         endcase
      end
      return r;
   endfunction

   logic [1:0] hand_ff, hand_in;
   logic [1:0] suit_ff, suit_in;
   logic [5:0] slot_ff, slot_in;
   logic [7:0] count_ff, count_in;
   logic       ended_ff, ended_in;
   logic       invalid_ff, invalid_in;
   logic       overflow_ff, overflow_in;

   logic       accept;
   logic       active;
   logic [7:0] chr;
   logic [3:0] rank;
   logic [5:0] base;
   logic [1:0] seat;
   logic       is_seat;
   op_type     op;

   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign chr        = req_data.char_byte;
   assign rank       = rank_of(chr);
   assign active     = !ended_ff && !invalid_ff && !overflow_ff;
   assign base       = 6'(hand_ff) * 6'(HAND_SIZE);
   assign push_valid = accept && (op.has_card || op.has_verdict);
   assign push_data  = op;

   always_comb begin
      is_seat = 1'b1;
      case (chr)
         CHAR_NORTH: seat = SEAT_NORTH;
         CHAR_EAST:  seat = SEAT_EAST;
         CHAR_SOUTH: seat = SEAT_SOUTH;
         CHAR_WEST:  seat = SEAT_WEST;
         default: begin
            seat    = SEAT_NORTH;
            is_seat = 1'b0;
         end
      endcase
   end

   always_comb begin
      hand_in     = hand_ff;
      suit_in     = suit_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      ended_in    = ended_ff;
      invalid_in  = invalid_ff;
      overflow_in = overflow_ff;
      op          = '0;
      op.verdict  = VERDICT_OK;
      if (accept) begin
         if (count_ff != 8'hFF) begin
            count_in = count_ff + 8'd1;
         end
         if (active) begin
            if (is_seat) begin
               hand_in = seat;
               suit_in = SUIT_SPADES;
               slot_in = 6'(seat) * 6'(HAND_SIZE);
            end else if (chr == CHAR_SPACE) begin
               hand_in = hand_ff;
            end else if (chr == CHAR_DOT) begin
               if (suit_ff == SUIT_CLUBS) begin
                  overflow_in = 1'b1;
               end else begin
                  suit_in = suit_ff - 2'd1;
               end
            end else if (chr == CHAR_SEMI || chr == CHAR_NEWLINE) begin
               ended_in = 1'b1;
            end else if (rank != RANK_NONE) begin
               if (slot_ff >= base + 6'(HAND_SIZE)) begin
                  overflow_in = 1'b1;
               end else begin
                  op.has_card   = 1'b1;
                  op.card_index = CARD_IDX_W'(6'(suit_ff) * 6'(HAND_SIZE) + 6'(rank));
                  op.slot       = slot_ff;
                  op.suit       = suit_ff;
                  op.rank       = rank;
                  slot_in       = slot_ff + 6'd1;
               end
            end else begin
               invalid_in = 1'b1;
            end
         end
         if (req_data.end_of_string) begin
            op.has_verdict = 1'b1;
            if (count_in < min_length) begin
               op.verdict = VERDICT_TOO_SHORT;
            end else if (invalid_in) begin
               op.verdict = VERDICT_INVALID;
            end else if (overflow_in) begin
               op.verdict = VERDICT_OVERFLOW;
            end else begin
               op.tally = 1'b1;
            end
            hand_in     = '0;
            suit_in     = '0;
            slot_in     = '0;
            count_in    = '0;
            ended_in    = 1'b0;
            invalid_in  = 1'b0;
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hand_ff     <= '0;
         suit_ff     <= '0;
         slot_ff     <= '0;
         count_ff    <= '0;
         ended_ff    <= 1'b0;
         invalid_ff  <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         hand_ff     <= hand_in;
         suit_ff     <= suit_in;
         slot_ff     <= slot_in;
         count_ff    <= count_in;
         ended_ff    <= ended_in;
         invalid_ff  <= invalid_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

// ===== rtl/bdtp_fifo.sv =====
// operation queue between the classifier and the tally stage
// depends on bdtp_pkg
module bdtp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  bdtp_pkg::op_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output bdtp_pkg::op_type pop_data
);

   import bdtp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type           entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/bdtp_back.sv =====
// tally stage: seen counters, card writes and verdicts
// depends on bdtp_pkg, bdtp_ram and the assertion macro header
module bdtp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  bdtp_pkg::op_type  pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdtp_pkg::rsp_type rsp_data
);

   import bdtp_pkg::*;

   `include "bridge_deal_text_parser_assert.svh"

   logic                  cur_valid_ff, cur_valid_in;
   op_type                cur_ff, cur_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [NUM_CARDS-1:0]  valid_ff, valid_in;
   logic [5:0]            ones_ff, ones_in;
   logic                  fwd_valid_ff;
   logic [CARD_IDX_W-1:0] fwd_addr_ff;
   logic [1:0]            fwd_data_ff;

   logic                  out_free;
   logic                  emit_card;
   logic                  emit_verdict;
   logic                  done;
   logic                  load;
   logic [CARD_IDX_W-1:0] rd_addr;
   logic [1:0]            rd_data;
   logic [1:0]            old_count;
   logic [1:0]            new_count;
   logic [5:0]            bad;

   bdtp_ram #(
      .WIDTH(2),
      .DEPTH(NUM_CARDS)
   ) u_seen_ram (
      .clock  (clock),
      .wr_en  (emit_card),
      .wr_addr(cur_ff.card_index),
      .wr_data(new_count),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign emit_card    = cur_valid_ff && cur_ff.has_card && out_free;
   assign emit_verdict = cur_valid_ff && !cur_ff.has_card && cur_ff.has_verdict && out_free;
   assign done         = (emit_card && !cur_ff.has_verdict) || emit_verdict;
   assign pop_ready    = !cur_valid_ff || done;
   assign load         = pop_valid && pop_ready;
   assign rd_addr      = load ? pop_data.card_index : cur_ff.card_index;
   assign bad          = 6'(NUM_CARDS) - ones_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // write from the previous cycle is not yet in the ram read data
   always_comb begin
      if (!valid_ff[cur_ff.card_index]) begin
         old_count = 2'd0;
      end else if (fwd_valid_ff && fwd_addr_ff == cur_ff.card_index) begin
         old_count = fwd_data_ff;
      end else begin
         old_count = rd_data;
      end
      new_count = (old_count == 2'd3) ? 2'd3 : old_count + 2'd1;
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      ones_in      = ones_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (emit_card) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in                 = '0;
         rsp_data_in.result_kind     = KIND_CARD;
         rsp_data_in.slot_index      = cur_ff.slot;
         rsp_data_in.suit_id         = cur_ff.suit;
         rsp_data_in.rank_id         = cur_ff.rank;
         rsp_data_in.verdict         = VERDICT_OK;
         rsp_data_in.last_result     = !cur_ff.has_verdict;
         valid_in[cur_ff.card_index] = 1'b1;
         cur_in.has_card             = 1'b0;
         if (old_count == 2'd0) begin
            ones_in = ones_ff + 6'd1;
         end else if (old_count == 2'd1) begin
            ones_in = ones_ff - 6'd1;
         end
      end
      if (emit_verdict) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in             = '0;
         rsp_data_in.result_kind = KIND_VERDICT;
         rsp_data_in.last_result = 1'b1;
         if (cur_ff.tally) begin
            rsp_data_in.verdict        = (bad != '0) ? VERDICT_BAD_CARDS : VERDICT_OK;
            rsp_data_in.bad_card_count = bad;
         end else begin
            rsp_data_in.verdict = cur_ff.verdict;
         end
         valid_in = '0;
         ones_in  = '0;
      end
      if (load) begin
         cur_valid_in = 1'b1;
         cur_in       = pop_data;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         ones_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         ones_ff      <= ones_in;
         fwd_valid_ff <= emit_card;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      fwd_addr_ff <= cur_ff.card_index;
      fwd_data_ff <= new_count;
   end

   `BDTP_ASSERT_NXT(a_verdict_clears_tally, clock, reset, emit_verdict, (ones_ff == '0) && (valid_ff == '0))
   `BDTP_ASSERT_IMP(a_ones_within_touched, clock, reset, 1'b1, int'(ones_ff) <= $countones(valid_ff))
   `BDTP_ASSERT_IMP(a_card_in_range, clock, reset, rsp_valid_ff && rsp_data_ff.result_kind == KIND_CARD, (rsp_data_ff.slot_index <= 6'd51) && (rsp_data_ff.rank_id <= 4'd12))

endmodule

// ===== sim/bridge_deal_text_parser_tb.sv =====
// testbench for the bridge deal text parser: directed strings, random and corrupted deals
// and noise go in one character per request while an in-bench parser predicts each response
// depends on bdtp_pkg and bridge_deal_text_parser
module bridge_deal_text_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bdtp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int MAX_PRINTED    = 40;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_data;

   // parser copy
   logic [1:0] card_seen [NUM_CARDS];
   logic [1:0] seat_now;
   logic [1:0] suit_now;
   logic [5:0] slot_now;
   logic [7:0] chars_seen;
   logic       text_closed;
   logic       invalid_hit;
   logic       overflow_hit;
   logic [7:0] min_len_cfg = MIN_LENGTH_RESET;

   rsp_type    parse_results_due [$];
   req_type    deal_chars [$];
   logic [7:0] deal_text [$];

   int mismatch_count = 0;
   int queued_count   = 0;
   int gap_pct        = 0;
   int long_tail_pct  = 0;
   int send_hold      = 0;
   int take_hold      = 0;
   int stall_cycles   = 0;

   bridge_deal_text_parser dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int rank_code(logic [7:0] c);
      if (c >= "2" && c <= "9") return c - "2";
      case (c)
         "T": return 8;
         "J": return 9;
         "Q": return 10;
         "K": return 11;
         "A": return 12;
         default: return 13;
      endcase
   endfunction

   function automatic logic [7:0] rank_char(int r);
      if (r < 8) return 8'("2" + r);
      case (r)
         8: return "T";
         9: return "J";
         10: return "Q";
         11: return "K";
         default: return "A";
      endcase
   endfunction

   function automatic logic [7:0] seat_char(int h);
      case (h)
         0: return "n";
         1: return "e";
         2: return "s";
         default: return "w";
      endcase
   endfunction

   function automatic void clear_parse_state();
      foreach (card_seen[i]) card_seen[i] = 2'd0;
      seat_now     = 2'd0;
      suit_now     = SUIT_CLUBS;
      slot_now     = 6'd0;
      chars_seen   = 8'd0;
      text_closed  = 1'b0;
      invalid_hit  = 1'b0;
      overflow_hit = 1'b0;
   endfunction

   task automatic parse_deal_char(req_type r);
      int          rank;
      int          idx;
      int          bad;
      rsp_type     w;
      verdict_type v;
      if (chars_seen != 8'hFF) chars_seen++;
      if (!text_closed && !invalid_hit && !overflow_hit) begin
         rank = rank_code(r.char_byte);
         case (r.char_byte)
            "n", "e", "s", "w": begin
               seat_now = (r.char_byte == "n") ? 2'd0 : (r.char_byte == "e") ? 2'd1 :
                          (r.char_byte == "s") ? 2'd2 : 2'd3;
               suit_now = SUIT_SPADES;
               slot_now = 6'(seat_now * HAND_SIZE);
            end
            CH_SPACE: ;
            CH_DOT: begin
               if (suit_now == SUIT_CLUBS) overflow_hit = 1'b1;
               else suit_now--;
            end
            CH_SEMI, CH_NEWLINE: text_closed = 1'b1;
            default: begin
               if (rank < 13) begin
                  if (slot_now >= seat_now * HAND_SIZE + HAND_SIZE) begin
                     overflow_hit = 1'b1;
                  end else begin
                     idx = suit_now * HAND_SIZE + rank;
                     if (card_seen[idx] != 2'd3) card_seen[idx]++;
                     w             = '0;
                     w.result_kind = KIND_CARD;
                     w.slot_index  = slot_now;
                     w.suit_id     = suit_now;
                     w.rank_id     = 4'(rank);
                     w.verdict     = VERDICT_OK;
                     w.last_result = !r.end_of_string;
                     parse_results_due.push_back(w);
                     slot_now++;
                  end
               end else begin
                  invalid_hit = 1'b1;
               end
            end
         endcase
      end
      if (r.end_of_string) begin
         bad = 0;
         if (chars_seen < min_len_cfg) v = VERDICT_TOO_SHORT;
         else if (invalid_hit) v = VERDICT_INVALID;
         else if (overflow_hit) v = VERDICT_OVERFLOW;
         else begin
            foreach (card_seen[i]) if (card_seen[i] != 2'd1) bad++;
            v = (bad != 0) ? VERDICT_BAD_CARDS : VERDICT_OK;
         end
         w                = '0;
         w.result_kind    = KIND_VERDICT;
         w.verdict        = v;
         w.bad_card_count = 6'(bad);
         w.last_result    = 1'b1;
         parse_results_due.push_back(w);
         clear_parse_state();
      end
   endtask

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      if (parse_results_due.size() == 0) begin
         report_mismatch("response with nothing outstanding");
         return;
      end
      want = parse_results_due.pop_front();
      compare_field("result_kind", got.result_kind, want.result_kind);
      compare_field("slot_index", got.slot_index, want.slot_index);
      compare_field("suit_id", got.suit_id, want.suit_id);
      compare_field("rank_id", got.rank_id, want.rank_id);
      compare_field("verdict", got.verdict, want.verdict);
      compare_field("bad_card_count", got.bad_card_count, want.bad_card_count);
      compare_field("last_result", got.last_result, want.last_result);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold <= 0;
      end else begin
         if (req_valid && req_ready) parse_deal_char(req_data);
         if (!req_valid || req_ready) begin
            if (send_hold != 0) begin
               send_hold <= send_hold - 1;
               req_valid <= 1'b0;
            end else if (deal_chars.size() == 0) begin
               req_valid <= 1'b0;
            end else if ($urandom_range(99, 0) < gap_pct) begin
               send_hold <= $urandom_range(15, 0);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= deal_chars.pop_front();
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_response(rsp_data);
         if (take_hold != 0) begin
            take_hold <= take_hold - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(99, 0) < gap_pct) begin
            take_hold <= $urandom_range(15, 0);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("bridge_deal_text_parser regression: fail");
      $finish;
   end

   task automatic send_text();
      req_type r;
      foreach (deal_text[i]) begin
         r.char_byte     = deal_text[i];
         r.end_of_string = (i == deal_text.size() - 1);
         deal_chars.push_back(r);
      end
      queued_count += deal_text.size();
   endtask

   task automatic load_text(string s);
      deal_text.delete();
      for (int i = 0; i < s.len(); i++) deal_text.push_back(s[i]);
   endtask

   task automatic build_deal();
      int deck [NUM_CARDS];
      int seat_order [4];
      int j;
      int t;
      bit held [NUM_CARDS];
      deal_text.delete();
      foreach (deck[i]) deck[i] = i;
      for (int i = NUM_CARDS - 1; i > 0; i--) begin
         j       = $urandom_range(i, 0);
         t       = deck[i];
         deck[i] = deck[j];
         deck[j] = t;
      end
      seat_order = '{0, 1, 2, 3};
      if ($urandom_range(3, 0) == 0) begin
         j             = $urandom_range(3, 1);
         t             = seat_order[0];
         seat_order[0] = seat_order[j];
         seat_order[j] = t;
      end
      for (int h = 0; h < 4; h++) begin
         foreach (held[i]) held[i] = 1'b0;
         for (int k = 0; k < HAND_SIZE; k++) held[deck[h * HAND_SIZE + k]] = 1'b1;
         if (h != 0) deal_text.push_back(CH_SPACE);
         deal_text.push_back(seat_char(seat_order[h]));
         deal_text.push_back(CH_SPACE);
         for (int s = 3; s >= 0; s--) begin
            for (int r = 12; r >= 0; r--)
               if (held[s * HAND_SIZE + r]) deal_text.push_back(rank_char(r));
            if (s != 0) deal_text.push_back(CH_DOT);
         end
      end
   endtask

   task automatic corrupt_deal();
      int pos;
      repeat ($urandom_range(2, 1)) begin
         pos = $urandom_range(deal_text.size() - 1, 0);
         case ($urandom_range(4, 0))
            0: deal_text[pos] = rank_char($urandom_range(12, 0));
            1: deal_text.delete(pos);
            2: deal_text.insert(pos, rank_char($urandom_range(12, 0)));
            3: deal_text.insert(pos, CH_DOT);
            default: deal_text.insert(pos, 8'($urandom_range(255, 0)));
         endcase
      end
   endtask

   task automatic build_noise();
      deal_text.delete();
      repeat ($urandom_range(30, 1)) begin
         case ($urandom_range(9, 0))
            0: deal_text.push_back(seat_char($urandom_range(3, 0)));
            1, 2, 3: deal_text.push_back(rank_char($urandom_range(12, 0)));
            4: deal_text.push_back(CH_DOT);
            5: deal_text.push_back(CH_SPACE);
            6: deal_text.push_back($urandom_range(1, 0) ? CH_SEMI : CH_NEWLINE);
            default: deal_text.push_back(8'($urandom_range(255, 0)));
         endcase
      end
   endtask

   task automatic add_tail();
      int tail_len;
      case ($urandom_range(3, 0))
         2: deal_text.push_back(CH_SEMI);
         3: deal_text.push_back(CH_NEWLINE);
         default: ;
      endcase
      if ($urandom_range(99, 0) < long_tail_pct) tail_len = $urandom_range(260, 180);
      else if ($urandom_range(1, 0) == 1) tail_len = $urandom_range(8, 1);
      else tail_len = 0;
      repeat (tail_len) deal_text.push_back(8'($urandom_range(255, 0)));
   endtask

   task automatic wait_drained();
      while (deal_chars.size() != 0 || req_valid || parse_results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int budget, int idle, int long_pct);
      int pick;
      @(negedge clock);
      gap_pct       = idle;
      long_tail_pct = long_pct;
      queued_count  = 0;
      while (queued_count < budget) begin
         pick = $urandom_range(99, 0);
         if (pick < 80) begin
            build_deal();
            if (pick >= 45) corrupt_deal();
         end else begin
            build_noise();
         end
         add_tail();
         send_text();
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_length(logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      min_len_cfg = value;
   endtask

   initial begin
      clear_parse_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // short directed strings at the reset minimum length
      @(negedge clock);
      deal_text = '{8'h00};
      send_text();
      load_text("AK");
      send_text();
      load_text("n....");
      send_text();
      load_text("w 2;");
      deal_text.push_back(8'hFF);
      send_text();
      load_text("sAKQJT987654322");
      send_text();
      run_phase(130, 10, 10);

      write_min_length(8'd0);
      run_phase(130, 0, 10);

      write_min_length(8'd255);
      run_phase(220, 15, 60);

      write_min_length(8'($urandom_range(80, 60)));
      run_phase(130, 25, 10);

      write_min_length(8'($urandom_range(255, 0)));
      run_phase(170, 0, 10);

      if (parse_results_due.size() != 0) report_mismatch("responses still outstanding at end");
      if (mismatch_count == 0) begin
         $display("bridge_deal_text_parser regression: pass");
      end else begin
         $display("bridge_deal_text_parser regression: fail");
      end
      $finish;
   end

endmodule
